// File: rtl/box_cox_derivative_top_assert.svh
// Assertion macros for the Box-Cox derivative block.
`ifndef BOX_COX_DERIVATIVE_TOP_ASSERT_SVH
`define BOX_COX_DERIVATIVE_TOP_ASSERT_SVH

// Check that cond_b holds in the same cycle as cond_a.
`define BCD_ASSERT_SAME(label, cond_a, cond_b, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |-> (cond_b)) else $error(msg);

// Check that cond_b holds in the cycle after cond_a.
`define BCD_ASSERT_NEXT(label, cond_a, cond_b, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |=> (cond_b)) else $error(msg);

`endif

// File: rtl/bcd_pkg.sv
package bcd_pkg;

    localparam int DIMS_DEF = 4;
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT0 = 4'd4;
    localparam logic signed [31:0] LAMBDA_RST = 32'sd65536;
    localparam logic signed [31:0] SHIFT_RST = 32'sd0;
    localparam logic [31:0] SLOPE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SMALL_LIMIT = 32'd253801;
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
    localparam int ITERS = 33;
    localparam int SQ_STEPS = 28;
    localparam int TAY_STAGES = 36;
    localparam logic [63:0] E_CAP = 64'd1 << 62;
    localparam logic [63:0] E_HI = 64'd15 << 44;
    localparam logic [63:0] E_LO = 64'd17 << 44;
    localparam logic [63:0] E_OFS = 64'd32 << 44;

    typedef struct packed {
        logic               vld;
        logic               bad;
        logic signed [31:0] lambda;
        logic [31:0]        xv;
        logic [4:0]         p;
        logic [31:0]        m;
        logic [27:0]        frac;
        logic [31:0]        rem;
        logic [32:0]        num;
        logic [32:0]        q;
    } t_front;

    typedef struct packed {
        logic        vld;
        logic        bad;
        logic        is_small;
        logic        zero;
        logic        big;
        logic        dsat;
        logic [31:0] dslope;
        logic [31:0] lmag;
        logic [32:0] lgmag;
        logic [31:0] amag;
        logic        neg;
        logic [63:0] emag;
        logic        esat;
        logic        eunf;
        logic [5:0]  rsh;
        logic [31:0] f32;
        logic [31:0] t;
        logic [31:0] term;
        logic [31:0] prod;
        logic [33:0] sum;
    } t_back;

endpackage

// File: rtl/box_cox_derivative_top.sv
// Box-Cox derivative: per transaction, x = value + shift[component], slope = x^(lambda-1)
// (or 1/x when |lambda*ln x| is below 1e-8), all signed Q16.16. Fully pipelined: one
// transaction enters per cycle unless the output stalls, and the depth is set by the
// 33-stage log2 squaring / reciprocal divider line and the 36-stage Taylor series of the
// exponential. A stalled output halts the whole pipeline; nothing is dropped.
`include "box_cox_derivative_top_assert.svh"

module box_cox_derivative_top #(
    parameter int DIMS = bcd_pkg::DIMS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_component,
    input  logic signed [31:0]            i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [31:0]            o_slope,
    output logic                          o_bad_input,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    logic signed [31:0] r_lambda [DIMS];
    logic signed [31:0] r_shift [DIMS];
    bcd_pkg::t_front    r_it [bcd_pkg::ITERS+1];
    bcd_pkg::t_front    n_it [bcd_pkg::ITERS+1];
    bcd_pkg::t_front    r_s0, n_s0;
    bcd_pkg::t_back     r_e1, n_e1, r_e2, n_e2, r_e3, n_e3, r_e4, n_e4;
    bcd_pkg::t_back     r_tay [bcd_pkg::TAY_STAGES+1];
    bcd_pkg::t_back     n_tay [bcd_pkg::TAY_STAGES+1];
    logic               r_out_vld, n_out_vld;
    logic [31:0]        r_slope, n_slope;
    logic               r_bad, n_bad, r_sat, n_sat;
    logic               w_adv;

    assign w_adv = !r_out_vld || i_out_ready;
    assign o_in_ready = w_adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_slope = $signed(r_slope);
    assign o_bad_input = r_bad;
    assign o_saturated = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIMS; i++) begin
                r_lambda[i] <= bcd_pkg::LAMBDA_RST;
                r_shift[i] <= bcd_pkg::SHIFT_RST;
            end
        end else if (i_cfg_valid) begin
            for (int i = 0; i < DIMS; i++) begin
                if (i_cfg_index == bcd_pkg::REG_LAMBDA0 + bcd_pkg::CFG_IDX_W'(i)) begin
                    r_lambda[i] <= $signed(i_cfg_data);
                end
                if (i_cfg_index == bcd_pkg::REG_SHIFT0 + bcd_pkg::CFG_IDX_W'(i)) begin
                    r_shift[i] <= $signed(i_cfg_data);
                end
            end
        end
    end

    always_comb begin
        logic signed [31:0] sel_l;
        logic signed [31:0] sel_s;
        logic               comp_ok;
        logic signed [33:0] x;
        sel_l = '0;
        sel_s = '0;
        comp_ok = 1'b0;
        for (int i = 0; i < DIMS; i++) begin
            if (i_component == 2'(i)) begin
                sel_l = r_lambda[i];
                sel_s = r_shift[i];
                comp_ok = 1'b1;
            end
        end
        x = 34'(i_value) + 34'(sel_s);
        n_s0 = '0;
        n_s0.vld = i_in_valid;
        n_s0.bad = !comp_ok || x[33] || (x == '0);
        n_s0.lambda = sel_l;
        n_s0.xv = x[31:0];
    end

    always_comb begin
        n_it[0] = r_s0;
        n_it[0].p = '0;
        for (int b = 0; b < 32; b++) begin
            if (r_s0.xv[b]) begin
                n_it[0].p = 5'(b);
            end
        end
        n_it[0].m = r_s0.xv << (5'd31 - n_it[0].p);
        n_it[0].frac = '0;
        n_it[0].rem = '0;
        n_it[0].num = {1'b1, 32'd0} + 33'(r_s0.xv >> 1);
        n_it[0].q = '0;
    end

    for (genvar j = 0; j < bcd_pkg::ITERS; j++) begin : g_it
        always_comb begin
            logic [32:0] rsh;
            logic [63:0] mm;
            logic [32:0] sq;
            n_it[j+1] = r_it[j];
            rsh = {r_it[j].rem, r_it[j].num[bcd_pkg::ITERS-1-j]};
            if (rsh >= {1'b0, r_it[j].xv}) begin
                n_it[j+1].rem = 32'(rsh - {1'b0, r_it[j].xv});
                n_it[j+1].q[bcd_pkg::ITERS-1-j] = 1'b1;
            end else begin
                n_it[j+1].rem = rsh[31:0];
            end
            mm = 64'(r_it[j].m) * 64'(r_it[j].m);
            sq = mm[63:31];
            if (j < bcd_pkg::SQ_STEPS) begin
                if (sq[32]) begin
                    n_it[j+1].m = sq[32:1];
                    n_it[j+1].frac = {r_it[j].frac[26:0], 1'b1};
                end else begin
                    n_it[j+1].m = sq[31:0];
                    n_it[j+1].frac = {r_it[j].frac[26:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        bcd_pkg::t_front     s;
        logic signed [6:0]   pe;
        logic signed [33:0]  lg;
        logic signed [32:0]  lam33;
        logic signed [32:0]  lm1;
        s = r_it[bcd_pkg::ITERS];
        pe = $signed({2'b00, s.p}) - 7'sd16;
        lg = ($signed(34'(pe)) <<< 28) + $signed({6'd0, s.frac});
        lam33 = 33'(s.lambda);
        lm1 = lam33 - 33'sd65536;
        n_e1 = '0;
        n_e1.vld = s.vld;
        n_e1.bad = s.bad;
        n_e1.lgmag = lg[33] ? 33'(-lg) : 33'(lg);
        n_e1.lmag = lam33[32] ? 32'(-lam33) : 32'(lam33);
        n_e1.amag = lm1[32] ? 32'(-lm1) : 32'(lm1);
        n_e1.neg = lm1[32] ^ lg[33];
        n_e1.zero = (n_e1.lmag == '0) || (n_e1.lgmag == '0);
        n_e1.big = (n_e1.lmag > bcd_pkg::SMALL_LIMIT)
                || (n_e1.lgmag > 33'(bcd_pkg::SMALL_LIMIT));
        n_e1.dsat = s.q > 33'(bcd_pkg::SLOPE_MAX);
        n_e1.dslope = n_e1.dsat ? bcd_pkg::SLOPE_MAX : s.q[31:0];
    end

    always_comb begin
        logic [35:0] sp;
        sp = 36'(r_e1.lmag[17:0]) * 36'(r_e1.lgmag[17:0]);
        n_e2 = r_e1;
        n_e2.is_small = r_e1.zero || (!r_e1.big && (sp <= 36'(bcd_pkg::SMALL_LIMIT)));
        if (r_e1.lgmag[32]) begin
            n_e2.emag = {r_e1.amag, 32'd0};
        end else begin
            n_e2.emag = 64'(r_e1.amag) * 64'(r_e1.lgmag[31:0]);
        end
    end

    always_comb begin
        n_e3 = r_e2;
        if (r_e2.emag > bcd_pkg::E_CAP) begin
            n_e3.emag = bcd_pkg::E_CAP;
        end
    end

    always_comb begin
        logic [63:0] eo;
        eo = r_e3.neg ? (bcd_pkg::E_OFS - r_e3.emag) : (bcd_pkg::E_OFS + r_e3.emag);
        n_e4 = r_e3;
        n_e4.esat = !r_e3.neg && (r_e3.emag >= bcd_pkg::E_HI);
        n_e4.eunf = r_e3.neg && (r_e3.emag > bcd_pkg::E_LO);
        n_e4.rsh = 6'd48 - eo[49:44];
        n_e4.f32 = eo[43:12];
    end

    always_comb begin
        logic [63:0] tp;
        tp = 64'(r_e4.f32) * 64'(bcd_pkg::LN2_Q32);
        n_tay[0] = r_e4;
        n_tay[0].t = tp[63:32];
        n_tay[0].term = tp[63:32];
        n_tay[0].sum = {2'b01, 32'd0} + 34'(tp[63:32]);
    end

    for (genvar g = 0; g < bcd_pkg::TAY_STAGES; g++) begin : g_tay
        localparam int K = 2 + g / 3;
        localparam int PH = g % 3;
        localparam logic [63:0] RECIP = (64'd1 << 32) / K;
        always_comb begin
            logic [63:0] mp;
            logic [32:0] rem;
            n_tay[g+1] = r_tay[g];
            rem = '0;
            if (PH == 0) begin
                mp = 64'(r_tay[g].term) * 64'(r_tay[g].t);
                n_tay[g+1].prod = mp[63:32];
            end else if (PH == 1) begin
                mp = 64'(r_tay[g].prod) * RECIP;
                n_tay[g+1].term = mp[63:32];
            end else begin
                mp = 64'(r_tay[g].term) * 64'(K);
                rem = 33'(r_tay[g].prod) - mp[32:0];
                if (rem >= 33'(K)) begin
                    n_tay[g+1].term = r_tay[g].term + 32'd1;
                end
                n_tay[g+1].sum = r_tay[g].sum + 34'(n_tay[g+1].term);
            end
        end
    end

    always_comb begin
        bcd_pkg::t_back s;
        logic [35:0]    res;
        s = r_tay[bcd_pkg::TAY_STAGES];
        res = (36'(s.sum) + (36'd1 << (s.rsh - 6'd1))) >> s.rsh;
        n_out_vld = s.vld;
        n_slope = '0;
        n_bad = 1'b0;
        n_sat = 1'b0;
        if (s.bad) begin
            n_bad = 1'b1;
        end else if (s.is_small) begin
            n_slope = s.dslope;
            n_sat = s.dsat;
        end else if (s.esat) begin
            n_slope = bcd_pkg::SLOPE_MAX;
            n_sat = 1'b1;
        end else if (s.eunf) begin
            n_slope = '0;
        end else if (res > 36'(bcd_pkg::SLOPE_MAX)) begin
            n_slope = bcd_pkg::SLOPE_MAX;
            n_sat = 1'b1;
        end else begin
            n_slope = res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            for (int i = 0; i <= bcd_pkg::ITERS; i++) begin
                r_it[i] <= '0;
            end
            r_e1 <= '0;
            r_e2 <= '0;
            r_e3 <= '0;
            r_e4 <= '0;
            for (int i = 0; i <= bcd_pkg::TAY_STAGES; i++) begin
                r_tay[i] <= '0;
            end
            r_out_vld <= 1'b0;
            r_slope <= '0;
            r_bad <= 1'b0;
            r_sat <= 1'b0;
        end else if (w_adv) begin
            r_s0 <= n_s0;
            for (int i = 0; i <= bcd_pkg::ITERS; i++) begin
                r_it[i] <= n_it[i];
            end
            r_e1 <= n_e1;
            r_e2 <= n_e2;
            r_e3 <= n_e3;
            r_e4 <= n_e4;
            r_tay[0] <= n_tay[0];
            for (int i = 1; i <= bcd_pkg::TAY_STAGES; i++) begin
                r_tay[i] <= n_tay[i];
            end
            r_out_vld <= n_out_vld;
            r_slope <= n_slope;
            r_bad <= n_bad;
            r_sat <= n_sat;
        end
    end

    `BCD_ASSERT_SAME(a_bad_zero, r_out_vld && r_bad, (r_slope == '0) && !r_sat, "bad input must give zero")
    `BCD_ASSERT_SAME(a_sat_max, r_out_vld && r_sat, r_slope == bcd_pkg::SLOPE_MAX, "saturation must clip")
    `BCD_ASSERT_SAME(a_stall, r_out_vld && !i_out_ready, !o_in_ready, "stalled pipeline accepted input")

endmodule

// File: test/testbench.sv
module testbench;

    localparam logic [bcd_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'd8;
    localparam int LOG_FRAC = 28;
    localparam int EXP_FRAC = 44;

    typedef struct packed {
        logic [1:0]  comp;
        logic [31:0] value;
    } t_sample;

    typedef struct packed {
        logic [31:0] slope;
        logic        bad;
        logic        sat;
    } t_slope;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_component = '0;
    logic [31:0] i_value = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [bcd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_slope;
    logic        o_bad_input;
    logic        o_saturated;
    logic        o_cfg_ready;

    logic [31:0] lambda_q [4];
    logic [31:0] shift_q [4];
    t_sample     pending_q [$];
    t_slope      slope_exp_q [$];
    int          send_idle = 0;
    int          recv_stall = 0;
    int          hold_cnt = 0;
    int          errors = 0;

    box_cox_derivative_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_component(i_component), .i_value(i_value),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_slope(o_slope), .o_bad_input(o_bad_input), .o_saturated(o_saturated),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint unsigned mag64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint log2_q28(longint unsigned xv);
        int p;
        longint unsigned m;
        longint fr;
        p = 0;
        fr = 0;
        while (p < 32 && (xv >> (p + 1)) != 0) p++;
        m = (p <= 31) ? (xv << (31 - p)) : (xv >> 1);
        for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        return longint'(p - 16) * (64'sd1 << LOG_FRAC) + fr;
    endfunction

    function automatic t_slope pow2_q16(bit neg, longint unsigned emag);
        t_slope r;
        longint unsigned eo, f32, t, term, sum, res;
        int n, sh;
        r = '0;
        if (!neg && emag >= bcd_pkg::E_HI) begin
            r.slope = bcd_pkg::SLOPE_MAX;
            r.sat = 1'b1;
            return r;
        end
        if (neg && emag > bcd_pkg::E_LO) return r;
        eo = neg ? bcd_pkg::E_OFS - emag : bcd_pkg::E_OFS + emag;
        n = int'(eo >> EXP_FRAC) - 32;
        f32 = (eo & ((64'd1 << EXP_FRAC) - 1)) >> (EXP_FRAC - 32);
        t = (f32 * 64'(bcd_pkg::LN2_Q32)) >> 32;
        term = 64'd1 << 32;
        sum = term;
        for (int k = 1; k <= 13; k++) begin
            term = ((term * t) >> 32) / longint'(k);
            sum += term;
        end
        sh = 16 - n;
        res = (sum + (64'd1 << (sh - 1))) >> sh;
        if (res > 64'(bcd_pkg::SLOPE_MAX)) begin
            r.slope = bcd_pkg::SLOPE_MAX;
            r.sat = 1'b1;
        end else begin
            r.slope = res[31:0];
        end
        return r;
    endfunction

    function automatic t_slope predict_slope(t_sample s);
        t_slope r;
        longint lam, x, lg, lm1;
        longint unsigned xu, lmag, gmag, amag, emag, q;
        bit tiny;
        r = '0;
        lam = longint'(signed'(lambda_q[s.comp]));
        x = longint'(signed'(s.value)) + longint'(signed'(shift_q[s.comp]));
        if (x <= 0) begin
            r.bad = 1'b1;
            return r;
        end
        xu = x;
        lg = log2_q28(xu);
        lmag = mag64(lam);
        gmag = mag64(lg);
        if (lmag == 0 || gmag == 0) tiny = 1'b1;
        else if (lmag > bcd_pkg::SMALL_LIMIT || gmag > bcd_pkg::SMALL_LIMIT) tiny = 1'b0;
        else tiny = (lmag * gmag) <= bcd_pkg::SMALL_LIMIT;
        if (tiny) begin
            q = ((64'd1 << 32) + (xu >> 1)) / xu;
            if (q > 64'(bcd_pkg::SLOPE_MAX)) begin
                r.slope = bcd_pkg::SLOPE_MAX;
                r.sat = 1'b1;
            end else begin
                r.slope = q[31:0];
            end
            return r;
        end
        lm1 = lam - 65536;
        amag = mag64(lm1);
        if (gmag != 0 && amag > bcd_pkg::E_CAP / gmag) emag = bcd_pkg::E_CAP;
        else emag = amag * gmag;
        return pow2_q16((lm1 < 0) != (lg < 0), emag);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                slope_exp_q.push_back(predict_slope({i_component, i_value}));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    t_sample s;
                    s = pending_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_component <= s.comp;
                    i_value <= s.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (slope_exp_q.size() == 0) begin
                    report_mismatch("unexpected transaction", o_slope, '0);
                end else begin
                    t_slope e;
                    e = slope_exp_q.pop_front();
                    if (o_slope !== e.slope) report_mismatch("slope", o_slope, e.slope);
                    if (o_bad_input !== e.bad) begin
                        report_mismatch("bad_input", 32'(o_bad_input), 32'(e.bad));
                    end
                    if (o_saturated !== e.sat) begin
                        report_mismatch("saturated", 32'(o_saturated), 32'(e.sat));
                    end
                end
            end
            if (hold_cnt > 0) hold_cnt = hold_cnt - 1;
            i_out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic cfg_write(logic [bcd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < bcd_pkg::REG_SHIFT0) lambda_q[idx[1:0]] = data;
        else if (idx < REG_SPARE) shift_q[2'(idx - bcd_pkg::REG_SHIFT0)] = data;
    endtask

    function automatic logic [31:0] pick_lambda();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($urandom_range(0, 600)) - 32'd300;
            2: return 32'($urandom_range(0, 524288)) - 32'd262144;
            3: return 32'($urandom_range(0, 2000)) + 32'd64536;
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_shift();
        case ($urandom_range(3))
            0: return '0;
            1: return $urandom;
            2: return 32'($urandom_range(0, 32'h40000)) - 32'h20000;
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic t_sample pick_sample();
        t_sample s;
        s.comp = 2'($urandom_range(3));
        case ($urandom_range(4))
            0: s.value = $urandom;
            1: s.value = 32'($urandom_range(1, 32'h40000)) - shift_q[s.comp];
            2: s.value = 32'h10000 + 32'($urandom_range(0, 510)) - 32'd255 - shift_q[s.comp];
            3: s.value = 32'($urandom_range(0, 20)) - 32'd4 - shift_q[s.comp];
            default: s.value = 32'($urandom_range(1, 32'h7FFF_FFFF)) - shift_q[s.comp];
        endcase
        return s;
    endfunction

    task automatic drain();
        while (pending_q.size() > 0 || i_in_valid || slope_exp_q.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int idle_sel [4][2] = '{'{0, 0}, '{69, 0}, '{0, 69}, '{23, 23}};
        for (int c = 0; c < 4; c++) begin
            lambda_q[c] = bcd_pkg::LAMBDA_RST;
            shift_q[c] = bcd_pkg::SHIFT_RST;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_write(bcd_pkg::REG_LAMBDA0 + 4'd1, '0);
        cfg_write(bcd_pkg::REG_LAMBDA0 + 4'd2, 32'h7FFF_FFFF);
        cfg_write(bcd_pkg::REG_LAMBDA0 + 4'd3, 32'h8000_0000);
        cfg_write(REG_SPARE + 4'd1, 32'h1234_5678);
        cfg_write(REG_SPARE + 4'd7, 32'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        pending_q.push_back({2'd0, 32'h0001_0000});
        pending_q.push_back({2'd0, 32'h8000_0000});
        pending_q.push_back({2'd0, 32'h7FFF_FFFF});
        pending_q.push_back({2'd0, 32'h0000_0000});
        pending_q.push_back({2'd0, 32'h0000_0001});
        pending_q.push_back({2'd0, 32'hFFFF_FFFF});
        pending_q.push_back({2'd0, 32'h0001_0001});
        pending_q.push_back({2'd0, 32'h0000_FFFF});
        pending_q.push_back({2'd1, 32'h0000_0001});
        pending_q.push_back({2'd1, 32'h0001_0000});
        pending_q.push_back({2'd1, 32'h7FFF_FFFF});
        pending_q.push_back({2'd1, 32'h0000_8000});
        pending_q.push_back({2'd2, 32'h0002_0000});
        pending_q.push_back({2'd2, 32'h0000_8000});
        pending_q.push_back({2'd2, 32'h0000_0001});
        pending_q.push_back({2'd2, 32'h7FFF_FFFF});
        pending_q.push_back({2'd3, 32'h0002_0000});
        pending_q.push_back({2'd3, 32'h0000_8000});
        pending_q.push_back({2'd3, 32'h0000_0001});
        pending_q.push_back({2'd3, 32'h7FFF_FFFF});
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            for (int c = 0; c < 4; c++) begin
                logic [31:0] lv, sv;
                lv = pick_lambda();
                sv = pick_shift();
                if (ph == 8) begin
                    lv = 32'h8000_0000;
                    sv = 32'h7FFF_FFFF;
                end else if (ph == 9) begin
                    lv = 32'h7FFF_FFFF;
                    sv = 32'h8000_0000;
                end
                cfg_write(bcd_pkg::REG_LAMBDA0 + 4'(c), lv);
                cfg_write(bcd_pkg::REG_SHIFT0 + 4'(c), sv);
            end
            i_cfg_valid <= 1'b0;
            send_idle = idle_sel[ph % 4][0];
            recv_stall = idle_sel[ph % 4][1];
            if (ph == 4) hold_cnt = 400;
            for (int n = 0; n < 160; n++) pending_q.push_back(pick_sample());
            drain();
        end

        send_idle = 0;
        recv_stall = 0;
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
